// ----- rtl/itl_pkg.sv -----
// itl_pkg: shared types and constants for the interval table lookup block
// operation and status codes, controller state, command and status groups
// no dependencies
package itl_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;

	typedef logic signed [DATA_W-1:0] q16_t;

	localparam q16_t POS_MAX = 32'sh7FFF_FFFF;
	localparam q16_t NEG_MIN = 32'sh8000_0000;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD    = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic needs_scan;
		logic last_addr;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/itl_req_if.sv -----
// itl_req_if: request channel of the interval table lookup block
// valid/ready handshake with one request word; depends on itl_pkg
interface itl_req_if import itl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	q16_t                lower_bound;
	q16_t                upper_bound;
	q16_t                level;
	q16_t                query_point;

	modport source (
		output valid, operation, lower_bound, upper_bound, level, query_point,
		input  ready
	);
	modport sink (
		input  valid, operation, lower_bound, upper_bound, level, query_point,
		output ready
	);
endinterface

// ----- rtl/itl_rsp_if.sv -----
// itl_rsp_if: response channel of the interval table lookup block
// valid/ready handshake with one result word; depends on itl_pkg
interface itl_rsp_if import itl_pkg::*; #(parameter int CNT_W = 7) ();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic                hit;
	q16_t                found_level;
	q16_t                lowest_start;
	q16_t                highest_end;
	logic [CNT_W-1:0]    entry_count;

	modport source (
		output valid, status, hit, found_level, lowest_start, highest_end, entry_count,
		input  ready
	);
	modport sink (
		input  valid, status, hit, found_level, lowest_start, highest_end, entry_count,
		output ready
	);
endinterface

// ----- rtl/interval_table_lookup_top.sv -----
// interval_table_lookup_top: table of half-open Q16.16 intervals with add, clear, lookup
// add or lookup with stored entries: the single read port scans one entry a cycle in S_SCAN,
// then S_DRAIN; clear, unused codes and an empty table go straight to S_DONE, which
// commits once the output is free; one word at a time, the next taken as the result shows
// reset: arst_n clears count and sets bounds to their extremes; entries stay as they are
// depends on itl_pkg, itl_req_if, itl_rsp_if, itl_ctrl, itl_dpath
module interval_table_lookup_top import itl_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input logic       clk,
	input logic       arst_n,
	itl_req_if.sink   req,
	itl_rsp_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;

	itl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	itl_dpath #(.ENTRIES(ENTRIES)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (req.operation),
		.lower_bound  (req.lower_bound),
		.upper_bound  (req.upper_bound),
		.level        (req.level),
		.query_point  (req.query_point),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.status       (rsp.status),
		.hit          (rsp.hit),
		.found_level  (rsp.found_level),
		.lowest_start (rsp.lowest_start),
		.highest_end  (rsp.highest_end),
		.entry_count  (rsp.entry_count)
	);

endmodule

// ----- rtl/itl_dpath.sv -----
// itl_dpath: entry memory, scan address counter, overlap and containment compare,
// running bounds, entry count and result register; depends on itl_pkg
module itl_dpath import itl_pkg::*; #(
	parameter  int ENTRIES = 64,
	localparam int CNT_W   = $clog2(ENTRIES + 1),
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [OP_W-1:0]   operation,
	input  q16_t              lower_bound,
	input  q16_t              upper_bound,
	input  q16_t              level,
	input  q16_t              query_point,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic              hit,
	output q16_t              found_level,
	output q16_t              lowest_start,
	output q16_t              highest_end,
	output logic [CNT_W-1:0]  entry_count
);

	localparam int MEM_W = 3 * DATA_W;

	logic [OP_W-1:0]   op_q;
	q16_t              lo_q, hi_q, lvl_q, pt_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	q16_t              min_q, min_d, max_q, max_d;
	logic [AW-1:0]     idx_q;
	logic              rd_vld_s1;
	logic [MEM_W-1:0]  rd_data_s1;
	logic [MEM_W-1:0]  mem_q [ENTRIES];
	logic              clash_q, hit_q;
	q16_t              found_q;
	logic              out_vld_q, hit_o_q;
	logic [STAT_W-1:0] status_q;
	q16_t              found_o_q;
	status_t           status_d;
	q16_t              rs, re, rl;
	logic              overlap, contains, full, wr_en;

	// request word capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			lo_q  <= lower_bound;
			hi_q  <= upper_bound;
			lvl_q <= level;
			pt_q  <= query_point;
		end
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cnt_q[AW-1:0]] <= {lo_q, hi_q, lvl_q};
		end
		if (cmd.step) begin
			rd_data_s1 <= mem_q[idx_q];
		end
	end

	assign rs = rd_data_s1[MEM_W-1 -: DATA_W];
	assign re = rd_data_s1[2*DATA_W-1 -: DATA_W];
	assign rl = rd_data_s1[DATA_W-1:0];

	assign overlap  = (rs < hi_q) && (lo_q < re);
	assign contains = (rs <= pt_q) && (re > pt_q);
	assign full     = (cnt_q >= CNT_W'(ENTRIES));
	assign wr_en    = cmd.commit && (op_q == OP_ADD) && !clash_q && !full;

	// scan counter and match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			clash_q   <= 1'b0;
			hit_q     <= 1'b0;
			found_q   <= '0;
		end else begin
			rd_vld_s1 <= cmd.step;
			if (cmd.load) begin
				idx_q   <= '0;
				clash_q <= 1'b0;
				hit_q   <= 1'b0;
				found_q <= '0;
			end else begin
				if (cmd.step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_vld_s1) begin
					if (op_q == OP_ADD && overlap) begin
						clash_q <= 1'b1;
					end
					if (op_q == OP_LOOKUP && !hit_q && contains) begin
						hit_q   <= 1'b1;
						found_q <= rl;
					end
				end
			end
		end
	end

	// table state after the operation
	always_comb begin
		cnt_d    = cnt_q;
		min_d    = min_q;
		max_d    = max_q;
		status_d = ST_OK;
		case (op_q)
			OP_CLEAR: begin
				cnt_d = '0;
				min_d = POS_MAX;
				max_d = NEG_MIN;
			end
			OP_ADD: begin
				if (clash_q) begin
					status_d = ST_OVERLAP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cnt_d = cnt_q + 1'b1;
					min_d = (cnt_q == '0 || lo_q < min_q) ? lo_q : min_q;
					max_d = (cnt_q == '0 || hi_q > max_q) ? hi_q : max_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_q <= POS_MAX;
			max_q <= NEG_MIN;
		end else if (cmd.commit) begin
			cnt_q <= cnt_d;
			min_q <= min_d;
			max_q <= max_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= status_d;
			hit_o_q   <= hit_q;
			found_o_q <= found_q;
		end
	end

	assign stat.needs_scan = (operation == OP_ADD || operation == OP_LOOKUP) && (cnt_q != '0);
	assign stat.last_addr  = (idx_q == AW'(cnt_q - 1'b1));
	assign stat.out_free   = !out_vld_q || out_ready;

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign hit          = hit_o_q;
	assign found_level  = found_o_q;
	assign lowest_start = min_q;
	assign highest_end  = max_q;
	assign entry_count  = cnt_q;

`ifndef SYNTH
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table depth");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("stored add did not bump the count");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> idx_q < cnt_q)
		else $error("scan read past the last stored entry");
	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> op_q == OP_LOOKUP)
		else $error("hit flag set outside a lookup");
`endif

endmodule

// ----- rtl/itl_ctrl.sv -----
// itl_ctrl: controller state machine sequencing accept, entry scan and commit
// depends on itl_pkg
module itl_ctrl import itl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = stat.needs_scan ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (stat.last_addr) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN: begin
				cmd.step = 1'b1;
			end
			S_DONE: begin
				cmd.commit = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule
